>>> rtl/pfbm_pkg.sv
// Package for the page frame buffer manager: command and status codes,
// request and result payload structs, and the sequencer state type. No dependencies.
package pfbm_pkg;

	typedef enum logic [2:0] {
		CMD_FETCH     = 3'd0,
		CMD_UNPIN     = 3'd1,
		CMD_FLUSH     = 3'd2,
		CMD_NEW       = 3'd3,
		CMD_DELETE    = 3'd4,
		CMD_FLUSH_ALL = 3'd5
	} cmd_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_NOFRAME  = 3'd2;
	localparam logic [2:0] ST_PINNED   = 3'd3;
	localparam logic [2:0] ST_PINLIMIT = 3'd4;

	localparam logic [7:0] PIN_MAX     = 8'd255;
	localparam int         MAX_RESULTS = 16;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  file_id;
		logic [23:0] page_no;
		logic        mark_dirty;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  frame;
		logic        read_request;
		logic        writeback_request;
		logic [7:0]  writeback_file;
		logic [23:0] writeback_page;
		logic        dealloc_request;
		logic        last;
	} rsp_t;

	// One metadata memory word per frame.
	typedef struct packed {
		logic        valid;
		logic [7:0]  file;
		logic [23:0] page;
		logic [7:0]  pin;
		logic        dirty;
	} meta_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_LAST,
		S_DECIDE,
		S_VICTIM,
		S_VREAD,
		S_APPLY,
		S_LRU,
		S_FA_READ,
		S_FA_CHECK,
		S_FA_LAST,
		S_OUT
	} state_t;

endpackage

>>> rtl/pfbm_lru.sv
// LRU rank list of unpinned frames, held as member bits and rank registers.
// Depends on pfbm_pkg for nothing beyond style; one operation per cycle.
module pfbm_lru import pfbm_pkg::*; #(
	parameter int POOL_SIZE = 16,
	parameter int FW = $clog2(POOL_SIZE)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          remove,
	input  logic          insert,
	input  logic [FW-1:0] target,
	output logic          oldest_found,
	output logic [FW-1:0] oldest
);

	logic [POOL_SIZE-1:0] member_q;
	logic [FW-1:0]        rank_q [POOL_SIZE];
	logic [FW:0]          size;

	// Member count and the frame holding rank zero.
	always_comb begin
		size         = '0;
		oldest_found = 1'b0;
		oldest       = '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			size = size + {{FW{1'b0}}, member_q[i]};
			if (member_q[i] && rank_q[i] == '0 && !oldest_found) begin
				oldest_found = 1'b1;
				oldest       = FW'(i);
			end
		end
	end

	// Removal closes the gap above the rank; insertion appends at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q <= '0;
			for (int i = 0; i < POOL_SIZE; i++) rank_q[i] <= '0;
		end else if (remove && member_q[target]) begin
			for (int i = 0; i < POOL_SIZE; i++)
				if (member_q[i] && rank_q[i] > rank_q[target])
					rank_q[i] <= rank_q[i] - 1'b1;
			member_q[target] <= 1'b0;
			rank_q[target]   <= '0;
		end else if (insert && !member_q[target]) begin
			member_q[target] <= 1'b1;
			rank_q[target]   <= size[FW-1:0];
		end
	end

endmodule

>>> rtl/pfbm_free_fifo.sv
// Free frame FIFO with a head pointer and fill count; resets to all frames in order.
// Depends on pfbm_pkg only by import convention.
module pfbm_free_fifo import pfbm_pkg::*; #(
	parameter int POOL_SIZE = 16,
	parameter int FW = $clog2(POOL_SIZE)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop,
	input  logic          push,
	input  logic [FW-1:0] push_frame,
	output logic          not_empty,
	output logic [FW-1:0] head
);

	logic [FW-1:0] slot_q [POOL_SIZE];
	logic [FW-1:0] head_q;
	logic [FW:0]   count_q;
	logic [FW:0]   tail_sum;
	logic [FW-1:0] tail;

	assign not_empty = count_q != '0;
	assign head      = slot_q[head_q];
	assign tail_sum  = (FW+1)'(head_q) + count_q;
	// The tail wraps at the pool size, which need not be a power of two.
	assign tail      = (tail_sum >= (FW+1)'(POOL_SIZE)) ?
		FW'(tail_sum - (FW+1)'(POOL_SIZE)) : FW'(tail_sum);

	// Ring buffer; a push into a full FIFO is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= (FW+1)'(POOL_SIZE);
			for (int i = 0; i < POOL_SIZE; i++) slot_q[i] <= FW'(i);
		end else if (pop && not_empty) begin
			head_q  <= (head_q == FW'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end else if (push && count_q < (FW+1)'(POOL_SIZE)) begin
			slot_q[tail] <= push_frame;
			count_q      <= count_q + 1'b1;
		end
	end

endmodule

>>> rtl/page_frame_buffer_manager.sv
// Top level of the page frame buffer manager: command sequencer, frame metadata
// memory, free FIFO and LRU list. Depends on pfbm_pkg, pfbm_free_fifo, pfbm_lru.
//
// Requests arrive on req (req_valid/req_ready); results leave on rsp
// (rsp_valid/rsp_ready), one per command except flush all, which gives one per dirty
// valid frame, at most MAX_RESULTS or one if none, and marks the final one with last.
// One request is handled at a time and req_ready is high only while idle. The
// page-table search reads the metadata memory one frame per cycle; a command that
// takes a victim frame then also reads that frame's old entry. The next request
// can be taken in the cycle after the result leaves.
// Flush all reads and then checks each frame in turn, and holds each writeback
// until the next dirty frame or the end of the walk is found.
// The result register holds its value while rsp_ready is low, and nothing moves
// on until it is taken.
// Reset clears all valid, pin and dirty marks, empties the LRU list and fills
// the free FIFO with frames 0 to POOL_SIZE-1; the block is ready at once.
module page_frame_buffer_manager import pfbm_pkg::*; #(
	parameter int POOL_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int FW = $clog2(POOL_SIZE);

	state_t        state_q, state_d;
	req_t          req_q;
	meta_t         mem [POOL_SIZE];
	meta_t         rd_s1;
	logic [FW-1:0] rd_addr;
	logic          mem_we;
	logic [FW-1:0] wr_addr;
	meta_t         wr_data;
	logic [FW-1:0] idx_q;
	logic          hit_q;
	meta_t         hit_meta_q;
	logic [FW-1:0] tgt_q;
	logic [4:0]    nres_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	logic          rsp_ld;
	rsp_t          pend_q;
	rsp_t          fa_rsp;
	logic          fa_end_q;
	logic          lru_rm, lru_ins, lru_found;
	logic [FW-1:0] lru_old, lru_tgt;
	logic          ff_pop, ff_push, ff_ne;
	logic [FW-1:0] ff_head;
	logic          match, fa_more, fa_found;

	pfbm_free_fifo #(.POOL_SIZE(POOL_SIZE), .FW(FW)) u_free (
		.clk, .arst_n, .pop(ff_pop), .push(ff_push), .push_frame(tgt_q),
		.not_empty(ff_ne), .head(ff_head)
	);

	pfbm_lru #(.POOL_SIZE(POOL_SIZE), .FW(FW)) u_lru (
		.clk, .arst_n, .remove(lru_rm), .insert(lru_ins), .target(lru_tgt),
		.oldest_found(lru_found), .oldest(lru_old)
	);

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = state_q == S_OUT;
	assign rsp       = rsp_q;
	assign match     = rd_s1.valid && rd_s1.file == req_q.file_id && rd_s1.page == req_q.page_no;
	assign fa_more   = idx_q != FW'(POOL_SIZE - 1);
	assign fa_found  = rd_s1.valid && rd_s1.dirty && nres_q < 5'(MAX_RESULTS);

	// Metadata memory: valid, pin and dirty are read as reset values until written via
	// the init marks below.
	logic [POOL_SIZE-1:0] init_q;
	meta_t                raw_s1;
	logic                 init_s1;
	always_ff @(posedge clk) begin
		raw_s1 <= mem[rd_addr];
		if (mem_we) mem[wr_addr] <= wr_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			init_s1 <= 1'b0;
		end else begin
			init_s1 <= init_q[rd_addr] || (mem_we && wr_addr == rd_addr);
			if (mem_we) init_q[wr_addr] <= 1'b1;
		end
	end
	always_comb begin
		rd_s1 = raw_s1;
		if (!init_s1) begin
			rd_s1.valid = 1'b0;
			rd_s1.pin   = '0;
			rd_s1.dirty = 1'b0;
		end
	end

	// Read address selection.
	always_comb begin
		unique case (state_q)
			S_IDLE:   rd_addr = '0;
			S_SCAN, S_FA_READ: rd_addr = idx_q;
			default:  rd_addr = tgt_q;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (req_valid)
				state_d = (req.command == CMD_FLUSH_ALL) ? S_FA_READ :
					(POOL_SIZE == 1 ? S_SCAN_LAST : S_SCAN);
			S_SCAN:      if (idx_q == FW'(POOL_SIZE - 1)) state_d = S_SCAN_LAST;
			S_SCAN_LAST: state_d = S_DECIDE;
			S_DECIDE: begin
				if ((req_q.command == CMD_FETCH && !hit_q) || req_q.command == CMD_NEW)
					state_d = S_VICTIM;
				else state_d = S_APPLY;
			end
			S_VICTIM:    state_d = (ff_ne || lru_found) ? S_VREAD : S_OUT;
			S_VREAD:     state_d = S_APPLY;
			S_APPLY:     state_d = S_LRU;
			S_LRU:       state_d = S_OUT;
			S_FA_READ:   state_d = S_FA_CHECK;
			S_FA_CHECK: begin
				if (fa_found && nres_q != '0) state_d = S_OUT;
				else if (fa_more) state_d = S_FA_READ;
				else state_d = S_FA_LAST;
			end
			S_FA_LAST:   state_d = S_OUT;
			S_OUT: if (rsp_ready) begin
				if (req_q.command == CMD_FLUSH_ALL && !rsp_q.last)
					state_d = fa_end_q ? S_FA_LAST : S_FA_READ;
				else state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Result build. During flush all one writeback is held back until it is
	// known whether a later dirty frame follows, so that last lands on it.
	always_comb begin
		fa_rsp                   = '0;
		fa_rsp.frame             = 4'(idx_q);
		fa_rsp.writeback_request = 1'b1;
		fa_rsp.writeback_file    = rd_s1.file;
		fa_rsp.writeback_page    = rd_s1.page;
		rsp_ld                   = 1'b0;
		rsp_d                    = '0;
		rsp_d.last               = 1'b1;
		unique case (state_q)
			S_VICTIM: if (!(ff_ne || lru_found)) begin
				rsp_ld       = 1'b1;
				rsp_d.status = ST_NOFRAME;
			end
			S_APPLY: begin
				rsp_ld      = 1'b1;
				rsp_d.frame = 4'(tgt_q);
				unique case (req_q.command)
					CMD_FETCH: if (!hit_q) begin
						rsp_d.read_request      = 1'b1;
						rsp_d.writeback_request = rd_s1.valid && rd_s1.dirty;
						if (rd_s1.valid && rd_s1.dirty) begin
							rsp_d.writeback_file = rd_s1.file;
							rsp_d.writeback_page = rd_s1.page;
						end
					end else if (hit_meta_q.pin == PIN_MAX) rsp_d.status = ST_PINLIMIT;
					CMD_NEW: begin
						rsp_d.writeback_request = rd_s1.valid && rd_s1.dirty;
						if (rd_s1.valid && rd_s1.dirty) begin
							rsp_d.writeback_file = rd_s1.file;
							rsp_d.writeback_page = rd_s1.page;
						end
					end
					CMD_UNPIN: if (!hit_q) begin
						rsp_d.status = ST_NOTFOUND;
						rsp_d.frame  = '0;
					end else if (hit_meta_q.pin == '0) rsp_d.status = ST_PINNED;
					CMD_FLUSH: if (!hit_q) begin
						rsp_d.status = ST_NOTFOUND;
						rsp_d.frame  = '0;
					end else begin
						rsp_d.writeback_request = 1'b1;
						rsp_d.writeback_file    = hit_meta_q.file;
						rsp_d.writeback_page    = hit_meta_q.page;
					end
					CMD_DELETE: if (!hit_q) rsp_d.frame = '0;
					else if (hit_meta_q.pin != '0) rsp_d.status = ST_PINNED;
					else rsp_d.dealloc_request = 1'b1;
					default: begin
						rsp_d.status = ST_NOTFOUND;
						rsp_d.frame  = '0;
					end
				endcase
			end
			S_FA_CHECK: if (fa_found && nres_q != '0) begin
				rsp_ld = 1'b1;
				rsp_d  = pend_q;
			end
			S_FA_LAST: begin
				rsp_ld = 1'b1;
				if (nres_q != '0) begin
					rsp_d      = pend_q;
					rsp_d.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Datapath and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_meta_q <= '0;
			tgt_q      <= '0;
			nres_q     <= '0;
			rsp_q      <= '0;
			pend_q     <= '0;
			fa_end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_ld) rsp_q <= rsp_d;
			unique case (state_q)
				S_IDLE: if (req_valid) begin
					req_q  <= req;
					idx_q  <= (req.command == CMD_FLUSH_ALL) ? '0 : FW'(1);
					hit_q  <= 1'b0;
					nres_q <= '0;
				end
				// First match of the search wins.
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (match && !hit_q) begin
						hit_q      <= 1'b1;
						hit_meta_q <= rd_s1;
						tgt_q      <= idx_q - 1'b1;
					end
				end
				S_SCAN_LAST: if (match && !hit_q) begin
					hit_q      <= 1'b1;
					hit_meta_q <= rd_s1;
					tgt_q      <= FW'(POOL_SIZE - 1);
				end
				S_VICTIM: tgt_q <= ff_ne ? ff_head : lru_old;
				S_FA_CHECK: begin
					if (fa_found) begin
						pend_q <= fa_rsp;
						nres_q <= nres_q + 1'b1;
					end
					if (fa_more) idx_q <= idx_q + 1'b1;
					fa_end_q <= !fa_more;
				end
				default: ;
			endcase
		end
	end

	// Memory writes, free FIFO and LRU updates.
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = tgt_q;
		wr_data = hit_meta_q;
		ff_pop  = 1'b0;
		ff_push = 1'b0;
		lru_rm  = 1'b0;
		lru_ins = 1'b0;
		lru_tgt = tgt_q;
		unique case (state_q)
			S_VICTIM: begin
				ff_pop  = ff_ne;
				lru_rm  = !ff_ne && lru_found;
				lru_tgt = lru_old;
			end
			S_APPLY: begin
				unique case (req_q.command)
					CMD_FETCH, CMD_NEW: begin
						if (req_q.command == CMD_NEW || !hit_q) begin
							mem_we  = 1'b1;
							wr_data = '{valid: 1'b1, file: req_q.file_id, page: req_q.page_no,
								pin: 8'd1, dirty: 1'b0};
						end else if (hit_meta_q.pin != PIN_MAX) begin
							mem_we      = 1'b1;
							wr_data.pin = hit_meta_q.pin + 1'b1;
						end
					end
					CMD_UNPIN: if (hit_q && hit_meta_q.pin != '0) begin
						mem_we      = 1'b1;
						wr_data.pin = hit_meta_q.pin - 1'b1;
						if (req_q.mark_dirty) wr_data.dirty = 1'b1;
					end
					CMD_FLUSH: if (hit_q) begin
						mem_we        = 1'b1;
						wr_data.dirty = 1'b0;
					end
					CMD_DELETE: if (hit_q && hit_meta_q.pin == '0) begin
						mem_we        = 1'b1;
						wr_data.valid = 1'b0;
						wr_data.dirty = 1'b0;
						ff_push       = 1'b1;
					end
					default: ;
				endcase
			end
			S_LRU: begin
				unique case (req_q.command)
					CMD_FETCH:  lru_rm  = 1'b1;
					CMD_NEW:    lru_rm  = 1'b1;
					CMD_DELETE: lru_rm  = hit_q && hit_meta_q.pin == '0;
					CMD_UNPIN:  lru_ins = hit_q && hit_meta_q.pin == 8'd1;
					default: ;
				endcase
				// Fetch at the pin limit leaves the list alone.
				if (req_q.command == CMD_FETCH && hit_q && hit_meta_q.pin == PIN_MAX)
					lru_rm = 1'b0;
			end
			S_FA_CHECK: if (fa_found) begin
				mem_we        = 1'b1;
				wr_addr       = idx_q;
				wr_data       = rd_s1;
				wr_data.dirty = 1'b0;
			end
			default: ;
		endcase
	end

endmodule

>>> dv/page_frame_buffer_manager_tb.sv
// Self-checking testbench for the page frame buffer manager: directed and random
// command streams checked against an in-bench model of the frame pool.
// Depends on pfbm_pkg and page_frame_buffer_manager.
module page_frame_buffer_manager_tb;
	import pfbm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NFRAMES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int EXP_DEPTH = 64;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	page_frame_buffer_manager #(.POOL_SIZE(NFRAMES)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Pool model state.
	logic        pool_valid [NFRAMES];
	logic [7:0]  pool_file [NFRAMES];
	logic [23:0] pool_page [NFRAMES];
	logic [7:0]  pool_pin [NFRAMES];
	logic        pool_dirty [NFRAMES];
	logic        lru_in [NFRAMES];
	int          lru_pos [NFRAMES];
	int          spare_frames [NFRAMES];
	int          spare_cnt;

	// Expected results, oldest first, in a ring.
	rsp_t exp_buf [EXP_DEPTH];
	int   exp_wr;
	int   exp_rd;
	int   error_count;
	int   rsp_count;
	int   cycle_count;
	int   writeback_count;
	bit   idle_enable;

	// Clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void exp_add(rsp_t r);
		exp_buf[exp_wr % EXP_DEPTH] = r;
		exp_wr++;
	endfunction

	function automatic int find_frame(logic [7:0] f, logic [23:0] p);
		for (int i = 0; i < NFRAMES; i++)
			if (pool_valid[i] && pool_file[i] == f && pool_page[i] == p)
				return i;
		return -1;
	endfunction

	function automatic void lru_drop(int fr);
		if (!lru_in[fr])
			return;
		for (int i = 0; i < NFRAMES; i++)
			if (lru_in[i] && lru_pos[i] > lru_pos[fr])
				lru_pos[i]--;
		lru_in[fr] = 1'b0;
		lru_pos[fr] = 0;
	endfunction

	function automatic void lru_append(int fr);
		int n;
		n = 0;
		if (lru_in[fr])
			return;
		for (int i = 0; i < NFRAMES; i++)
			n += lru_in[i];
		lru_pos[fr] = n;
		lru_in[fr] = 1'b1;
	endfunction

	function automatic rsp_t blank_rsp(logic [2:0] st, int fr);
		rsp_t r;
		r = '0;
		r.status = st;
		r.frame = fr[3:0];
		r.last = 1'b1;
		return r;
	endfunction

	// Maps a page into a victim frame, free frames first, else the oldest LRU one.
	function automatic rsp_t map_page(logic [7:0] f, logic [23:0] p, logic rd);
		rsp_t r;
		int v;
		v = -1;
		if (spare_cnt > 0) begin
			v = spare_frames[0];
			for (int i = 0; i < NFRAMES - 1; i++)
				spare_frames[i] = spare_frames[i + 1];
			spare_cnt--;
		end else
			for (int i = 0; i < NFRAMES; i++)
				if (lru_in[i] && lru_pos[i] == 0)
					v = i;
		if (v < 0)
			return blank_rsp(ST_NOFRAME, 0);
		lru_drop(v);
		r = blank_rsp(ST_OK, v);
		r.read_request = rd;
		if (pool_valid[v] && pool_dirty[v]) begin
			r.writeback_request = 1'b1;
			r.writeback_file = pool_file[v];
			r.writeback_page = pool_page[v];
		end
		pool_dirty[v] = 1'b0;
		pool_valid[v] = 1'b1;
		pool_file[v] = f;
		pool_page[v] = p;
		pool_pin[v] = 8'd1;
		return r;
	endfunction

	// Applies one command to the pool model and queues its results.
	function automatic void predict_command(req_t c);
		rsp_t r;
		int fr;
		int n;
		fr = find_frame(c.file_id, c.page_no);
		case (c.command)
			CMD_FETCH: begin
				if (fr < 0)
					r = map_page(c.file_id, c.page_no, 1'b1);
				else if (pool_pin[fr] >= PIN_MAX)
					r = blank_rsp(ST_PINLIMIT, fr);
				else begin
					pool_pin[fr]++;
					lru_drop(fr);
					r = blank_rsp(ST_OK, fr);
				end
				exp_add(r);
			end
			CMD_UNPIN: begin
				if (fr < 0)
					r = blank_rsp(ST_NOTFOUND, 0);
				else if (pool_pin[fr] == 0)
					r = blank_rsp(ST_PINNED, fr);
				else begin
					pool_pin[fr]--;
					if (pool_pin[fr] == 0)
						lru_append(fr);
					if (c.mark_dirty)
						pool_dirty[fr] = 1'b1;
					r = blank_rsp(ST_OK, fr);
				end
				exp_add(r);
			end
			CMD_FLUSH: begin
				if (fr < 0)
					r = blank_rsp(ST_NOTFOUND, 0);
				else begin
					pool_dirty[fr] = 1'b0;
					r = blank_rsp(ST_OK, fr);
					r.writeback_request = 1'b1;
					r.writeback_file = pool_file[fr];
					r.writeback_page = pool_page[fr];
				end
				exp_add(r);
			end
			CMD_NEW: exp_add(map_page(c.file_id, c.page_no, 1'b0));
			CMD_DELETE: begin
				if (fr < 0)
					r = blank_rsp(ST_OK, 0);
				else if (pool_pin[fr] > 0)
					r = blank_rsp(ST_PINNED, fr);
				else begin
					pool_valid[fr] = 1'b0;
					pool_dirty[fr] = 1'b0;
					lru_drop(fr);
					if (spare_cnt < NFRAMES) begin
						spare_frames[spare_cnt] = fr;
						spare_cnt++;
					end
					r = blank_rsp(ST_OK, fr);
					r.dealloc_request = 1'b1;
				end
				exp_add(r);
			end
			CMD_FLUSH_ALL: begin
				n = 0;
				for (int i = 0; i < NFRAMES && n < MAX_RESULTS; i++)
					if (pool_valid[i] && pool_dirty[i]) begin
						pool_dirty[i] = 1'b0;
						r = blank_rsp(ST_OK, i);
						r.last = 1'b0;
						r.writeback_request = 1'b1;
						r.writeback_file = pool_file[i];
						r.writeback_page = pool_page[i];
						exp_add(r);
						n++;
					end
				if (n == 0)
					exp_add(blank_rsp(ST_OK, 0));
				else
					exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
			end
			default: exp_add(blank_rsp(ST_NOTFOUND, 0));
		endcase
	endfunction

	// Sends one request, with a random gap before it, and predicts its results.
	task automatic send_request(logic [2:0] cmd, logic [7:0] f, logic [23:0] p,
			logic d);
		req_t c;
		c.command = cmd;
		c.file_id = f;
		c.page_no = p;
		c.mark_dirty = d;
		while (idle_enable && $urandom_range(99) < 38)
			@(posedge clk);
		req_valid <= 1'b1;
		req <= c;
		do
			@(posedge clk);
		while (!req_ready);
		predict_command(c);
		req_valid <= 1'b0;
		req <= req_t'({$urandom(), 4'($urandom())});
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (exp_wr != exp_rd)
			@(posedge clk);
	endtask

	// Result checker with a randomly stalling receiver.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_count++;
				if (rsp.writeback_request)
					writeback_count++;
				if (exp_wr == exp_rd) begin
					$display("%0t: unexpected result %h", $realtime, rsp);
					error_count++;
				end else begin
					e = exp_buf[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (rsp !== e) begin
						$display("%0t: result mismatch expected %h actual %h",
							$realtime, e, rsp);
						$display("  st %0d/%0d fr %0d/%0d rd %b/%b wb %b/%b",
							e.status, rsp.status, e.frame, rsp.frame,
							e.read_request, rsp.read_request,
							e.writeback_request, rsp.writeback_request);
						$display("  wf %h/%h wp %h/%h dl %b/%b last %b/%b",
							e.writeback_file, rsp.writeback_file,
							e.writeback_page, rsp.writeback_page,
							e.dealloc_request, rsp.dealloc_request, e.last, rsp.last);
						error_count++;
					end
				end
			end
			rsp_ready <= !idle_enable || ($urandom_range(99) >= 38);
		end
	end

	// Directed: every command, misses, pinned delete, flush all.
	task automatic test_directed();
		send_request(CMD_UNPIN, 8'h00, 24'h0, 1'b0);
		send_request(CMD_FLUSH, 8'hFF, 24'hFFFFFF, 1'b0);
		send_request(CMD_DELETE, 8'h01, 24'h1, 1'b0);
		send_request(CMD_FLUSH_ALL, 8'h00, 24'h0, 1'b0);
		send_request(3'd6, 8'h00, 24'h0, 1'b0);
		send_request(3'd7, 8'hFF, 24'hFFFFFF, 1'b1);
		send_request(CMD_FETCH, 8'hFF, 24'hFFFFFF, 1'b0);
		send_request(CMD_FETCH, 8'hFF, 24'hFFFFFF, 1'b0);
		send_request(CMD_NEW, 8'h00, 24'h000000, 1'b0);
		send_request(CMD_NEW, 8'h00, 24'h000000, 1'b0);
		send_request(CMD_DELETE, 8'hFF, 24'hFFFFFF, 1'b0);
		send_request(CMD_UNPIN, 8'hFF, 24'hFFFFFF, 1'b1);
		send_request(CMD_UNPIN, 8'hFF, 24'hFFFFFF, 1'b0);
		send_request(CMD_UNPIN, 8'hFF, 24'hFFFFFF, 1'b0);
		send_request(CMD_FLUSH, 8'hFF, 24'hFFFFFF, 1'b0);
		send_request(CMD_UNPIN, 8'h00, 24'h000000, 1'b1);
		send_request(CMD_FLUSH_ALL, 8'hAB, 24'h0, 1'b0);
		send_request(CMD_DELETE, 8'h00, 24'h000000, 1'b0);
		send_request(CMD_DELETE, 8'hFF, 24'hFFFFFF, 1'b0);
	endtask

	// Pin one frame past the limit, the first half with no idling, then unpin a
	// few times. The frame stays pinned for the rest of the run.
	task automatic test_pin_limit();
		idle_enable = 1'b0;
		for (int i = 0; i < 257; i++) begin
			if (i == 128)
				idle_enable = 1'b1;
			send_request(CMD_FETCH, 8'h5A, 24'hA5A5A5, 1'b0);
		end
		for (int i = 0; i < 4; i++)
			send_request(CMD_UNPIN, 8'h5A, 24'hA5A5A5, i[0]);
	endtask

	// Fill every frame with pinned pages so that a miss finds no victim.
	task automatic test_pool_full();
		for (int i = 0; i < NFRAMES + 1; i++)
			send_request(CMD_NEW, 8'h20, 24'(i), 1'b0);
		send_request(CMD_FETCH, 8'h21, 24'h0, 1'b0);
		for (int i = 0; i < NFRAMES; i++)
			send_request(CMD_UNPIN, 8'h20, 24'(i), i[0]);
		send_request(CMD_FETCH, 8'h21, 24'h1, 1'b0);
		send_request(CMD_FLUSH_ALL, 8'h00, 24'h0, 1'b0);
		wait_drained();
	endtask

	// Random traffic on a small set of pages so that hits, evictions and
	// deletes are frequent; a few items use fully random fields.
	task automatic test_random(int count);
		logic [7:0] f;
		logic [23:0] p;
		int k;
		for (int i = 0; i < count; i++) begin
			idle_enable = !(i >= count / 3 && i < count / 3 + 60);
			k = $urandom_range(99);
			f = 8'($urandom_range(3));
			p = 24'($urandom_range(23));
			if (k < 8) begin
				f = 8'($urandom());
				p = 24'($urandom());
			end
			k = $urandom_range(99);
			if (k < 30)
				send_request(CMD_FETCH, f, p, 1'b0);
			else if (k < 60)
				send_request(CMD_UNPIN, f, p, 1'($urandom()));
			else if (k < 68)
				send_request(CMD_FLUSH, f, p, 1'b0);
			else if (k < 80)
				send_request(CMD_NEW, f, p, 1'b0);
			else if (k < 92)
				send_request(CMD_DELETE, f, p, 1'b0);
			else if (k < 97)
				send_request(CMD_FLUSH_ALL, f, p, 1'b0);
			else
				send_request(3'($urandom_range(7)), f, p, 1'($urandom()));
			if (i == count / 2)
				wait_drained();
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		int guard;
		for (int i = 0; i < NFRAMES; i++) begin
			pool_valid[i] = 1'b0;
			pool_file[i] = '0;
			pool_page[i] = '0;
			pool_pin[i] = '0;
			pool_dirty[i] = 1'b0;
			lru_in[i] = 1'b0;
			lru_pos[i] = 0;
			spare_frames[i] = i;
		end
		spare_cnt = NFRAMES;
		exp_wr = 0;
		exp_rd = 0;
		error_count = 0;
		rsp_count = 0;
		cycle_count = 0;
		writeback_count = 0;
		idle_enable = 1'b1;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pool_full();
		test_pin_limit();
		test_random(50);

		wait_drained();
		guard = 0;
		while (guard < 4 * NFRAMES + 40) begin
			@(posedge clk);
			guard++;
		end
		$display("Checked %0d results (%0d writebacks) over fetch, unpin, flush,",
			rsp_count, writeback_count);
		$display("new, delete, flush all, invalid codes, full pool and pin limit.");
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pfbm_pkg.sv
rtl/pfbm_lru.sv
rtl/pfbm_free_fifo.sv
rtl/page_frame_buffer_manager.sv
dv/page_frame_buffer_manager_tb.sv
